>>> rtl/core/clsr_pkg.sv
// Shared constants of the combined generator with shuffle table.
// Used by the modular multiplier and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package clsr_pkg;

    // Width of one generator value and of one result word.
    localparam int VALUE_W = 31;
    // Width of the generator multipliers.
    localparam int MUL_W = 16;
    // Width of a full multiplier product.
    localparam int GEN_PROD_W = MUL_W + VALUE_W;
    // Width of the folding constant 2^31 - modulus.
    localparam int FOLD_W = 8;

    // First generator: modulus 2^31 - 85.
    localparam logic [VALUE_W-1:0] MOD1   = 31'd2147483563;
    localparam logic [VALUE_W-1:0] MOD1M1 = 31'd2147483562;
    localparam logic [MUL_W-1:0]   MUL1   = 16'd40014;
    localparam logic [FOLD_W-1:0]  FOLD1  = 8'd85;

    // Second generator: modulus 2^31 - 249.
    localparam logic [VALUE_W-1:0] MOD2  = 31'd2147483399;
    localparam logic [MUL_W-1:0]   MUL2  = 16'd40692;
    localparam logic [FOLD_W-1:0]  FOLD2 = 8'd249;

    // Reset value of the second generator.
    localparam logic [VALUE_W-1:0] SEED2_RESET = 31'd123456789;

    // Steps of the first generator that run before the table fill starts.
    localparam int WARMUP = 8;

    // Operation codes carried in tuser.
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/clsr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the shuffle table of the generator.
`timescale 1ns / 1ps
`default_nettype none

module clsr_ram #(
    parameter int DATA_W = 31,
    parameter int DEPTH  = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/clsr_modmul.sv
// Two-lane modular multiplier: one lane per congruential generator.
// Uses constants of clsr_pkg; products and reductions are registered, no flow control.
`timescale 1ns / 1ps
`default_nettype none

module clsr_modmul (
    input  wire logic                          aclk,
    input  wire logic [clsr_pkg::VALUE_W-1:0]  x1,
    input  wire logic [clsr_pkg::VALUE_W-1:0]  x2,
    output logic      [clsr_pkg::VALUE_W-1:0]  r1,
    output logic      [clsr_pkg::VALUE_W-1:0]  r2
);

    localparam int VW = clsr_pkg::VALUE_W;
    localparam int PW = clsr_pkg::GEN_PROD_W;
    localparam int HW = PW - VW;

    logic [PW-1:0] p1_reg, p1_next;
    logic [PW-1:0] p2_reg, p2_next;
    logic [VW-1:0] r1_reg, r1_next;
    logic [VW-1:0] r2_reg, r2_next;

    // Reduce a product modulo 2^31 - fold. Since 2^31 is congruent to fold,
    // the high part times fold plus the low part stays below twice the
    // modulus, so one conditional subtract finishes the reduction.
    function automatic logic [VW-1:0] fold_reduce(
        input logic [PW-1:0]                 prod,
        input logic [clsr_pkg::FOLD_W-1:0]   fold,
        input logic [VW-1:0]                 modulus
    );
        logic [HW+clsr_pkg::FOLD_W-1:0] hi_scaled;
        logic [VW:0]                    sum;
        hi_scaled   = (HW + clsr_pkg::FOLD_W)'(prod[PW-1:VW]) *
                      (HW + clsr_pkg::FOLD_W)'(fold);
        sum         = (VW + 1)'(prod[VW-1:0]) + (VW + 1)'(hi_scaled);
        if (sum >= (VW + 1)'(modulus)) begin
            sum = sum - (VW + 1)'(modulus);
        end
        fold_reduce = sum[VW-1:0];
    endfunction

    // Stage one: the products.
    assign p1_next = PW'(clsr_pkg::MUL1) * PW'(x1);
    assign p2_next = PW'(clsr_pkg::MUL2) * PW'(x2);

    // Stage two: the reductions.
    assign r1_next = fold_reduce(p1_reg, clsr_pkg::FOLD1, clsr_pkg::MOD1);
    assign r2_next = fold_reduce(p2_reg, clsr_pkg::FOLD2, clsr_pkg::MOD2);

    always_ff @(posedge aclk) begin
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        r1_reg <= r1_next;
        r2_reg <= r2_next;
    end

    assign r1 = r1_reg;
    assign r2 = r2_reg;

endmodule

`default_nettype wire

>>> rtl/core/combined_lcg_shuffle_rng.sv
// Combined congruential random number generator with a shuffle table.
// Depends on clsr_pkg, clsr_modmul and clsr_ram.
//
// Usage:
//   The slave stream carries one command word per number wanted. tuser holds
//   the operation (draw, or reseed then draw); tdata holds the seed, which
//   only a reseed uses. Every accepted word gives exactly one master word
//   whose tdata holds a raw value in 1 .. 2147483562.
//   A draw passes from acceptance through the two-stage modular multiplier
//   pair (accepting state, then draw wait), the table update and the slot
//   computation of the next draw (multiply, compare) before its result is
//   registered on the master side. A new word is accepted in the cycle
//   after the result is registered, so the block works on one word at a
//   time.
//   A reseed steps the first generator forty times through the same
//   multiplier loop (step wait, step write-back) before its draw.
//   The shuffle table sits in a RAM with a registered read; one read
//   and one write per draw.
//   After reset the generators hold 1 and 123456789 and the table reads as
//   zeros through per-entry valid bits; no clearing pass is needed.
//   When the receiver stalls, the result waits in the output register; the
//   block takes the next word meanwhile and holds its own result until the
//   register is free.
`timescale 1ns / 1ps
`default_nettype none

module combined_lcg_shuffle_rng #(
    parameter int TABLE_SIZE = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Command words.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] seed_magnitude, [31] zero pad
    input  wire logic [0:0]  s_tuser,   // [0] opcode
    // Result words.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [30:0] random_value, [31] zero pad
);

    localparam int VW       = clsr_pkg::VALUE_W;
    localparam int SLOT_W   = $clog2(TABLE_SIZE);
    localparam int CNT_W    = $clog2(TABLE_SIZE + clsr_pkg::WARMUP);
    localparam int QW       = $clog2(TABLE_SIZE + 1);
    localparam longint unsigned DIVISOR =
        1 + longint'(clsr_pkg::MOD1M1) / TABLE_SIZE;
    localparam int RECIP_SHIFT = 40;
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DIVISOR;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int DPROD_W  = VW + RECIP_W;
    localparam int BOUND_W  = QW + VW + 1;
    localparam logic [VW-1:0]      DIV_VAL   = VW'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'(RECIP);
    localparam logic [QW:0]        SLOT_MAX  = (QW + 1)'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0]   CNT_START =
        CNT_W'(TABLE_SIZE + clsr_pkg::WARMUP - 1);
    localparam logic [CNT_W-1:0]   CNT_TABLE = CNT_W'(TABLE_SIZE);

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_STEP_WAIT  = 9'b000000010,
        ST_STEP_WB    = 9'b000000100,
        ST_DRAW_ISSUE = 9'b000001000,
        ST_DRAW_WAIT  = 9'b000010000,
        ST_DRAW_UPD   = 9'b000100000,
        ST_DIV_MUL    = 9'b001000000,
        ST_DIV_CMP    = 9'b010000000,
        ST_FINISH     = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [VW-1:0]       first_gen_reg, first_gen_next;
    logic [VW-1:0]       second_gen_reg, second_gen_next;
    logic [VW-1:0]       shuffle_out_reg, shuffle_out_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TABLE_SIZE-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                reseed_pend_reg, reseed_pend_next;
    logic [DPROD_W-1:0]  div_prod_reg, div_prod_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [VW-1:0]       m_tdata_reg, m_tdata_next;

    logic                in_fire;
    logic                start_reseed;
    logic [VW-1:0]       seed_in;
    logic [VW-1:0]       seed_eff;
    logic                out_free;

    logic [VW-1:0]       mm_x1;
    logic [VW-1:0]       g1_res;
    logic [VW-1:0]       g2_res;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [VW-1:0]       ram_wdata;
    logic                ram_re;
    logic [VW-1:0]       ram_rdata;

    logic [VW-1:0]       tab_val;
    logic [VW:0]         diff;
    logic [VW:0]         diff_wrap;
    logic [VW-1:0]       draw_out;

    logic [QW-1:0]       q_est;
    logic [QW:0]         q_inc;
    logic [BOUND_W-1:0]  bound;
    logic [QW:0]         q_fix;
    logic [SLOT_W-1:0]   slot_calc;

    // Input decode: a reseed is forced when the first generator sits at zero.
    assign in_fire      = s_tvalid && s_tready;
    assign seed_in      = s_tdata[VW-1:0];
    assign start_reseed = (s_tuser[0] == clsr_pkg::OP_RESEED) || (first_gen_reg == '0);
    always_comb begin
        if (s_tuser[0] == clsr_pkg::OP_RESEED && seed_in != '0) begin
            seed_eff = seed_in;
        end else begin
            seed_eff = VW'(1);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Multiplier operand: a reseed loop forwards the last step's result.
    always_comb begin
        case (state_reg)
            ST_IDLE:    mm_x1 = start_reseed ? seed_eff : first_gen_reg;
            ST_STEP_WB: mm_x1 = g1_res;
            default:    mm_x1 = first_gen_reg;
        endcase
    end

    clsr_modmul u_modmul (
        .aclk (aclk),
        .x1   (mm_x1),
        .x2   (second_gen_reg),
        .r1   (g1_res),
        .r2   (g2_res)
    );

    clsr_ram #(
        .DATA_W (VW),
        .DEPTH  (TABLE_SIZE)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // New output: table entry minus the second generator, wrapped into range.
    assign tab_val   = valid_reg[slot_reg] ? ram_rdata : '0;
    assign diff      = {1'b0, tab_val} - {1'b0, g2_res};
    assign diff_wrap = diff + {1'b0, clsr_pkg::MOD1M1};
    assign draw_out  = (diff[VW] || diff == '0) ? diff_wrap[VW-1:0] : diff[VW-1:0];

    // Slot of the next draw: reciprocal estimate, one correction, clamp.
    assign q_est = QW'(div_prod_reg >> RECIP_SHIFT);
    assign q_inc = (QW + 1)'(q_est) + (QW + 1)'(1);
    assign bound = BOUND_W'(q_inc) * BOUND_W'(DIV_VAL);
    always_comb begin
        if (bound <= BOUND_W'(shuffle_out_reg)) begin
            q_fix = q_inc;
        end else begin
            q_fix = (QW + 1)'(q_est);
        end
        if (q_fix > SLOT_MAX) begin
            slot_calc = SLOT_W'(SLOT_MAX);
        end else begin
            slot_calc = SLOT_W'(q_fix);
        end
    end

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        first_gen_next   = first_gen_reg;
        second_gen_next  = second_gen_reg;
        shuffle_out_next = shuffle_out_reg;
        slot_next        = slot_reg;
        valid_next       = valid_reg;
        cnt_next         = cnt_reg;
        reseed_pend_next = reseed_pend_reg;
        div_prod_next    = div_prod_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        ram_wdata        = g1_res;
        ram_re           = 1'b0;
        s_tready         = 1'b0;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_fire) begin
                    if (start_reseed) begin
                        first_gen_next   = seed_eff;
                        second_gen_next  = seed_eff;
                        cnt_next         = CNT_START;
                        reseed_pend_next = 1'b1;
                        state_next       = ST_STEP_WAIT;
                    end else begin
                        ram_re     = 1'b1;
                        state_next = ST_DRAW_WAIT;
                    end
                end
            end
            ST_STEP_WAIT: begin
                state_next = ST_STEP_WB;
            end
            ST_STEP_WB: begin
                first_gen_next = g1_res;
                if (cnt_reg < CNT_TABLE) begin
                    ram_we                 = 1'b1;
                    ram_waddr              = cnt_reg[SLOT_W-1:0];
                    valid_next[ram_waddr]  = 1'b1;
                end
                if (cnt_reg == '0) begin
                    shuffle_out_next = g1_res;
                    state_next       = ST_DIV_MUL;
                end else begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_STEP_WAIT;
                end
            end
            ST_DRAW_ISSUE: begin
                ram_re     = 1'b1;
                state_next = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: begin
                state_next = ST_DRAW_UPD;
            end
            ST_DRAW_UPD: begin
                first_gen_next        = g1_res;
                second_gen_next       = g2_res;
                shuffle_out_next      = draw_out;
                ram_we                = 1'b1;
                valid_next[slot_reg]  = 1'b1;
                state_next            = ST_DIV_MUL;
            end
            ST_DIV_MUL: begin
                div_prod_next = DPROD_W'(shuffle_out_reg) * DPROD_W'(RECIP_VAL);
                state_next    = ST_DIV_CMP;
            end
            ST_DIV_CMP: begin
                slot_next = slot_calc;
                if (reseed_pend_reg) begin
                    reseed_pend_next = 1'b0;
                    state_next       = ST_DRAW_ISSUE;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = shuffle_out_reg;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = shuffle_out_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and generator state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            first_gen_reg   <= VW'(1);
            second_gen_reg  <= clsr_pkg::SEED2_RESET;
            shuffle_out_reg <= '0;
            slot_reg        <= '0;
            valid_reg       <= '0;
            cnt_reg         <= '0;
            reseed_pend_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            first_gen_reg   <= first_gen_next;
            second_gen_reg  <= second_gen_next;
            shuffle_out_reg <= shuffle_out_next;
            slot_reg        <= slot_next;
            valid_reg       <= valid_next;
            cnt_reg         <= cnt_next;
            reseed_pend_reg <= reseed_pend_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        div_prod_reg <= div_prod_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_tdata_reg};

    // The table is never read and written in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("shuffle table read and write collide");

    // Every result word lies in 1 .. modulus-1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VW-1:0] != '0) && (m_tdata[VW-1:0] < clsr_pkg::MOD1))
        else $error("result word out of range");

    // One word at a time: after an acceptance the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while one is in work");

    // The slot register always addresses a real table entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (SLOT_W + 1)'(slot_reg) < (SLOT_W + 1)'(TABLE_SIZE))
        else $error("slot beyond table");

    // Multiplier results are fully reduced when a draw consumes them.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW_UPD) |-> (g1_res < clsr_pkg::MOD1) && (g2_res < clsr_pkg::MOD2))
        else $error("generator step not reduced");

endmodule

`default_nettype wire

>>> tb/combined_lcg_shuffle_rng_tb.sv
// Self-checking bench for the combined congruential generator with shuffle table.
// Streams draw and reseed words into the block and checks every result word
// against an in-bench model of both generators and the table; needs clsr_pkg.
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_tb;

    localparam int TABLE_SIZE = 32;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 12;
    localparam int RANDOM_WORDS = 1280;

    // Schrage decomposition constants of the two generators.
    localparam longint QUO1 = 53668;
    localparam longint REM1 = 12211;
    localparam longint QUO2 = 52774;
    localparam longint REM2 = 3791;
    localparam longint MOD1_L = clsr_pkg::MOD1;
    localparam longint MOD2_L = clsr_pkg::MOD2;
    localparam longint MOD1M1_L = clsr_pkg::MOD1M1;
    localparam longint MUL1_L = clsr_pkg::MUL1;
    localparam longint MUL2_L = clsr_pkg::MUL2;
    localparam longint SLOT_DIV = 1 + MOD1M1_L / TABLE_SIZE;
    localparam logic [30:0] SEED_MAX = 31'h7FFFFFFF;

    // One command word plus the flow control it asks of the driver.
    typedef struct {
        logic        op;
        logic [30:0] seed;
        bit          drain_first;
        bit          calm;
    } command_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    command_t    pending_cmds[$];
    logic [30:0] expected_values[$];
    command_t    active_cmd;
    logic        calm_phase = 1'b0;

    // Model state of the generators and the shuffle table.
    longint gen_a;
    longint gen_b;
    longint last_out;
    longint shuffle_tab[TABLE_SIZE];

    int error_count = 0;
    int draw_count = 0;
    int reseed_count = 0;
    int restart_count = 0;
    int result_count = 0;
    int issued = 0;
    int retired = 0;
    int gap_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    combined_lcg_shuffle_rng #(
        .TABLE_SIZE(TABLE_SIZE)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // One multiplicative congruential step by Schrage's method.
    function automatic longint lcg_step(longint x, longint mul, longint quo, longint rem,
                                        longint modulus);
        longint hi;
        longint r;
        hi = x / quo;
        r = mul * (x - hi * quo) - hi * rem;
        if (r < 0)
            r += modulus;
        return r;
    endfunction

    // Load a seed, warm up the first generator and fill the table.
    task automatic refill_table(longint seed);
        if (seed < 1)
            seed = 1;
        gen_a = seed;
        gen_b = seed;
        for (int j = TABLE_SIZE + clsr_pkg::WARMUP - 1; j >= 0; j--) begin
            gen_a = lcg_step(gen_a, MUL1_L, QUO1, REM1, MOD1_L);
            if (j < TABLE_SIZE)
                shuffle_tab[j] = gen_a;
        end
        last_out = shuffle_tab[0];
    endtask

    // Advance both generators and swap one table entry for the next number.
    function automatic logic [30:0] draw_value();
        longint slot;
        gen_a = lcg_step(gen_a, MUL1_L, QUO1, REM1, MOD1_L);
        gen_b = lcg_step(gen_b, MUL2_L, QUO2, REM2, MOD2_L);
        slot = last_out / SLOT_DIV;
        if (slot < 0)
            slot = 0;
        if (slot >= TABLE_SIZE)
            slot = TABLE_SIZE - 1;
        last_out = shuffle_tab[slot] - gen_b;
        shuffle_tab[slot] = gen_a;
        if (last_out < 1)
            last_out += MOD1M1_L;
        return last_out[30:0];
    endfunction

    // Work out the number that an accepted word must produce.
    task automatic predict_number(command_t cmd);
        if (cmd.op == clsr_pkg::OP_RESEED) begin
            reseed_count++;
            refill_table(longint'(cmd.seed));
        end else begin
            draw_count++;
            if (gen_a <= 0) begin
                restart_count++;
                refill_table(1);
            end
        end
        expected_values = {expected_values, draw_value()};
    endtask

    task automatic report_error(string what, logic [30:0] got, logic [30:0] want);
        if (error_count < 30)
            $display("ERROR %0t: %s: got %0d, want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_cmd(logic op, logic [30:0] seed, bit drain_first, bit calm);
        command_t c;
        c.op = op;
        c.seed = seed;
        c.drain_first = drain_first;
        c.calm = calm;
        pending_cmds = {pending_cmds, c};
    endtask

    // Driver: presents queued command words, with random gaps between them.
    always @(posedge aclk) begin : drive_words
        bit accepted;
        command_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            accepted = s_tvalid && s_tready;
            if (accepted) begin
                predict_number(active_cmd);
                issued++;
            end
            if (m_tvalid && m_tready)
                retired++;
            if (s_tvalid && !accepted) begin
                // Hold the word until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_cmds[0].drain_first && issued != retired) begin
                s_tvalid <= 1'b0;
            end else begin
                nxt = pending_cmds.pop_front();
                active_cmd = nxt;
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, nxt.seed};
                s_tuser <= nxt.op;
                calm_phase <= nxt.calm;
                if (!nxt.calm && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 7);
            end
        end
    end

    // Monitor: checks each result word and stalls the master side at random.
    always @(posedge aclk) begin : check_words
        logic [30:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    report_error("result word with nothing expected", m_tdata[30:0], '0);
                end else begin
                    want = expected_values.pop_front();
                    result_count++;
                    if (m_tdata[30:0] !== want)
                        report_error("random_value", m_tdata[30:0], want);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("combined_lcg_shuffle_rng: mismatch");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : run_test
        logic        op;
        logic [30:0] seed;
        bit          calm;
        bit          drain;

        gen_a = 1;
        gen_b = clsr_pkg::SEED2_RESET;
        last_out = 0;
        for (int i = 0; i < TABLE_SIZE; i++)
            shuffle_tab[i] = 0;

        // Directed part: draws on the zeroed table, then the seed corners.
        add_cmd(clsr_pkg::OP_DRAW, SEED_MAX, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, 31'h2AAAAAAA, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, 31'd1, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        // A seed equal to the first modulus zeroes the first generator, so the
        // first draw after it restarts from seed one.
        add_cmd(clsr_pkg::OP_RESEED, clsr_pkg::MOD1, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, clsr_pkg::MOD1M1, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, SEED_MAX, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, clsr_pkg::MOD1 + 31'd1, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, SEED_MAX, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, clsr_pkg::MOD2, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, 31'h55555555, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, 31'h2AAAAAAA, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_RESEED, 31'd12345, 1'b1, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);
        add_cmd(clsr_pkg::OP_DRAW, '0, 1'b0, 1'b0);

        // Random part: long draw runs broken up by reseeds.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= 520 && n < 620) || (n >= RANDOM_WORDS - 150);
            drain = (n == 300) || (n == 900);
            seed = 31'($urandom);
            op = clsr_pkg::OP_DRAW;
            if ($urandom_range(0, 11) == 0) begin
                op = clsr_pkg::OP_RESEED;
                case ($urandom_range(0, 9))
                    0: seed = '0;
                    1: seed = clsr_pkg::MOD1;
                    2: seed = 31'($urandom_range(SEED_MAX, clsr_pkg::MOD1));
                    3: seed = 31'($urandom_range(1, 255));
                    default: seed = 31'($urandom);
                endcase
            end
            add_cmd(op, seed, drain, calm);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid || expected_values.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_values.size() != 0)
            report_error("results never arrived", '0, '0);
        $display("Covered %0d draws and %0d reseeds, %0d restarts from a zero generator.",
                 draw_count, reseed_count, restart_count);
        $display("Checked %0d result words, %0d errors.", result_count, error_count);
        if (error_count == 0) begin
            $display("combined_lcg_shuffle_rng: match");
        end else begin
            $display("combined_lcg_shuffle_rng: mismatch");
        end
        $finish;
    end

endmodule
